### src/ibdp_pkg.sv
// Shared types, field slot codes and decode functions of the indoor bike data parser.
`timescale 1ns / 1ps

package ibdp_pkg;

   localparam int unsigned FIELD_COUNT = 12;

   // Field slot codes in packet order; SLOT_DONE marks that every field has been received.
   localparam logic [3:0] SLOT_SPEED      = 4'd0;
   localparam logic [3:0] SLOT_AVG_SPEED  = 4'd1;
   localparam logic [3:0] SLOT_CADENCE    = 4'd2;
   localparam logic [3:0] SLOT_AVG_CAD    = 4'd3;
   localparam logic [3:0] SLOT_DISTANCE   = 4'd4;
   localparam logic [3:0] SLOT_RESIST     = 4'd5;
   localparam logic [3:0] SLOT_POWER      = 4'd6;
   localparam logic [3:0] SLOT_AVG_POWER  = 4'd7;
   localparam logic [3:0] SLOT_ENERGY     = 4'd8;
   localparam logic [3:0] SLOT_HEART      = 4'd9;
   localparam logic [3:0] SLOT_METABOLIC  = 4'd10;
   localparam logic [3:0] SLOT_ELAPSED    = 4'd11;
   localparam logic [3:0] SLOT_DONE       = 4'd12;

   localparam logic [1:0] HEADER_BYTES    = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } ibdp_beat_type;

   typedef struct packed {
      logic               record_valid;
      logic [15:0]        flag_word;
      logic [15:0]        speed_raw;
      logic [15:0]        cadence_raw;
      logic [23:0]        distance_m;
      logic signed [15:0] resistance_level;
      logic               has_resistance;
      logic signed [15:0] power_w;
      logic [15:0]        energy_total;
      logic [7:0]         heart_rate;
      logic [15:0]        elapsed_s;
   } ibdp_record_type;

   // Length in bytes of each field.
   function automatic logic [2:0] field_len(input logic [3:0] slot);
      logic [2:0] len;
      unique case (slot) inside
         SLOT_DISTANCE:              len = 3'd3;
         SLOT_ENERGY:                len = 3'd5;
         SLOT_HEART, SLOT_METABOLIC: len = 3'd1;
         default:                    len = 3'd2;
      endcase
      return len;
   endfunction

   // Speed is present when flag bit 0 is clear; every other field when its bit is set.
   function automatic logic [FIELD_COUNT-1:0] field_mask(input logic [15:0] flags);
      return {flags[FIELD_COUNT-1:1], ~flags[0]};
   endfunction

   // First present field at or after the given slot, SLOT_DONE if there is none.
   function automatic logic [3:0] next_field(input logic [FIELD_COUNT-1:0] mask,
                                             input logic [3:0] from);
      logic [3:0] slot;
      slot = SLOT_DONE;
      for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
         if (mask[i] && (4'(i) >= from)) begin
            slot = 4'(i);
         end
      end
      return slot;
   endfunction

endpackage

### src/ibdp_if.sv
// Handshake interfaces for the packet byte channel and the record channel.
`timescale 1ns / 1ps

interface ibdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ibdp_rsp_if;
   logic               valid;
   logic               ready;
   logic               record_valid;
   logic [15:0]        flag_word;
   logic [15:0]        speed_raw;
   logic [15:0]        cadence_raw;
   logic [23:0]        distance_m;
   logic signed [15:0] resistance_level;
   logic               has_resistance;
   logic signed [15:0] power_w;
   logic [15:0]        energy_total;
   logic [7:0]         heart_rate;
   logic [15:0]        elapsed_s;

   modport source (output valid, output record_valid, output flag_word, output speed_raw,
                   output cadence_raw, output distance_m, output resistance_level,
                   output has_resistance, output power_w, output energy_total,
                   output heart_rate, output elapsed_s, input ready);
   modport sink   (input valid, input record_valid, input flag_word, input speed_raw,
                   input cadence_raw, input distance_m, input resistance_level,
                   input has_resistance, input power_w, input energy_total,
                   input heart_rate, input elapsed_s, output ready);
endinterface

### src/ibdp_in_stage.sv
// Input register that captures one packet byte beat ahead of the parser.
`timescale 1ns / 1ps

module ibdp_in_stage
   import ibdp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ibdp_req_if.sink      req_ch,
   input  logic          take,
   output logic          beat_valid,
   output ibdp_beat_type beat
);

   logic          valid_ff;
   logic          valid_in;
   ibdp_beat_type beat_ff;
   logic          accept;

   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         beat_ff.data_byte <= req_ch.data_byte;
         beat_ff.last_byte <= req_ch.last_byte;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

### src/ibdp_parser.sv
// Field sequencer: flag word capture, field assembly and the record built at the last byte.
`timescale 1ns / 1ps

module ibdp_parser
   import ibdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  ibdp_beat_type   beat,
   output ibdp_record_type record
);

   logic [15:0] flag_ff,     flag_in;
   logic [1:0]  header_ff,   header_in;
   logic [3:0]  slot_ff,     slot_in;
   logic [2:0]  bslot_ff,    bslot_in;
   logic [23:0] assemble_ff, assemble_in;
   logic [15:0] speed_ff,    speed_in;
   logic [15:0] cadence_ff,  cadence_in;
   logic [23:0] distance_ff, distance_in;
   logic [15:0] resist_ff,   resist_in;
   logic        has_res_ff,  has_res_in;
   logic [15:0] power_ff,    power_in;
   logic [15:0] energy_ff,   energy_in;
   logic [7:0]  heart_ff,    heart_in;
   logic [15:0] elapsed_ff,  elapsed_in;

   logic [23:0] assemble_next;
   logic [2:0]  byte_count;

   always_comb begin
      flag_in     = flag_ff;
      header_in   = header_ff;
      slot_in     = slot_ff;
      bslot_in    = bslot_ff;
      assemble_in = assemble_ff;
      speed_in    = speed_ff;
      cadence_in  = cadence_ff;
      distance_in = distance_ff;
      resist_in   = resist_ff;
      has_res_in  = has_res_ff;
      power_in    = power_ff;
      energy_in   = energy_ff;
      heart_in    = heart_ff;
      elapsed_in  = elapsed_ff;
      // Only the first three bytes of a field are kept; the tail of energy is dropped.
      assemble_next = assemble_ff;
      if (bslot_ff < 3'd3) begin
         assemble_next = assemble_ff | (24'(beat.data_byte) << {bslot_ff[1:0], 3'b000});
      end
      byte_count = bslot_ff + 3'd1;

      if (step) begin
         if (header_ff != HEADER_BYTES) begin
            if (header_ff == 2'd0) begin
               flag_in = {8'h00, beat.data_byte};
            end else begin
               flag_in = {beat.data_byte, flag_ff[7:0]};
            end
            header_in = header_ff + 2'd1;
            if (header_in == HEADER_BYTES) begin
               slot_in     = next_field(field_mask(flag_in), SLOT_SPEED);
               bslot_in    = 3'd0;
               assemble_in = 24'd0;
            end
         end else if (slot_ff != SLOT_DONE) begin
            if (byte_count >= field_len(slot_ff)) begin
               case (slot_ff)
                  SLOT_SPEED:    speed_in    = assemble_next[15:0];
                  SLOT_CADENCE:  cadence_in  = assemble_next[15:0];
                  SLOT_DISTANCE: distance_in = assemble_next;
                  SLOT_RESIST: begin
                     resist_in  = assemble_next[15:0];
                     has_res_in = 1'b1;
                  end
                  SLOT_POWER:    power_in    = assemble_next[15:0];
                  SLOT_ENERGY:   energy_in   = assemble_next[15:0];
                  SLOT_HEART:    heart_in    = assemble_next[7:0];
                  SLOT_ELAPSED:  elapsed_in  = assemble_next[15:0];
                  default: ;
               endcase
               slot_in     = next_field(field_mask(flag_ff), slot_ff + 4'd1);
               bslot_in    = 3'd0;
               assemble_in = 24'd0;
            end else begin
               bslot_in    = byte_count;
               assemble_in = assemble_next;
            end
         end
      end

      // The record reflects the state after the last byte has been taken in.
      record.record_valid     = (header_in == HEADER_BYTES) && (slot_in == SLOT_DONE);
      record.flag_word        = (header_in == HEADER_BYTES) ? flag_in : 16'd0;
      record.speed_raw        = speed_in;
      record.cadence_raw      = cadence_in;
      record.distance_m       = distance_in;
      record.resistance_level = resist_in;
      record.has_resistance   = has_res_in;
      record.power_w          = power_in;
      record.energy_total     = energy_in;
      record.heart_rate       = heart_in;
      record.elapsed_s        = elapsed_in;

      // The last byte closes the packet and the sequencer starts afresh.
      if (step && beat.last_byte) begin
         flag_in     = 16'd0;
         header_in   = 2'd0;
         slot_in     = SLOT_SPEED;
         bslot_in    = 3'd0;
         assemble_in = 24'd0;
         speed_in    = 16'd0;
         cadence_in  = 16'd0;
         distance_in = 24'd0;
         resist_in   = 16'd0;
         has_res_in  = 1'b0;
         power_in    = 16'd0;
         energy_in   = 16'd0;
         heart_in    = 8'd0;
         elapsed_in  = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff     <= 16'd0;
         header_ff   <= 2'd0;
         slot_ff     <= SLOT_SPEED;
         bslot_ff    <= 3'd0;
         assemble_ff <= 24'd0;
         speed_ff    <= 16'd0;
         cadence_ff  <= 16'd0;
         distance_ff <= 24'd0;
         resist_ff   <= 16'd0;
         has_res_ff  <= 1'b0;
         power_ff    <= 16'd0;
         energy_ff   <= 16'd0;
         heart_ff    <= 8'd0;
         elapsed_ff  <= 16'd0;
      end else begin
         flag_ff     <= flag_in;
         header_ff   <= header_in;
         slot_ff     <= slot_in;
         bslot_ff    <= bslot_in;
         assemble_ff <= assemble_in;
         speed_ff    <= speed_in;
         cadence_ff  <= cadence_in;
         distance_ff <= distance_in;
         resist_ff   <= resist_in;
         has_res_ff  <= has_res_in;
         power_ff    <= power_in;
         energy_ff   <= energy_in;
         heart_ff    <= heart_in;
         elapsed_ff  <= elapsed_in;
      end
   end

endmodule

### src/ibdp_rsp_stage.sv
// Result register that holds one finished record until the consumer takes it.
`timescale 1ns / 1ps

module ibdp_rsp_stage
   import ibdp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  ibdp_record_type record,
   ibdp_rsp_if.source      rsp_ch
);

   logic            valid_ff;
   logic            valid_in;
   ibdp_record_type record_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         record_ff <= record;
      end
   end

   assign rsp_ch.valid            = valid_ff;
   assign rsp_ch.record_valid     = record_ff.record_valid;
   assign rsp_ch.flag_word        = record_ff.flag_word;
   assign rsp_ch.speed_raw        = record_ff.speed_raw;
   assign rsp_ch.cadence_raw      = record_ff.cadence_raw;
   assign rsp_ch.distance_m       = record_ff.distance_m;
   assign rsp_ch.resistance_level = record_ff.resistance_level;
   assign rsp_ch.has_resistance   = record_ff.has_resistance;
   assign rsp_ch.power_w          = record_ff.power_w;
   assign rsp_ch.energy_total     = record_ff.energy_total;
   assign rsp_ch.heart_rate       = record_ff.heart_rate;
   assign rsp_ch.elapsed_s        = record_ff.elapsed_s;

endmodule

### src/indoor_bike_data_parser_unit.sv
// Top level of the indoor bike data parser: input register, field sequencer, result register.
//
//   Channel  Direction  Beat carries
//   req_ch   in         one packet byte and its last-byte marker
//   rsp_ch   out        one decoded record per packet, sent after the last byte
//
// One byte beat is accepted every cycle unless a last byte is held back; the field sequencer
// handles each registered byte; the result register takes the record with its last byte.
// Reset is synchronous and returns the sequencer to the start of a packet.
// A last byte waits in the input register while an earlier record is still unread; other
// bytes keep flowing, since they produce no record.
`timescale 1ns / 1ps

module indoor_bike_data_parser_unit
   import ibdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ibdp_req_if.sink   req_ch,
   ibdp_rsp_if.source rsp_ch
);

   logic            beat_valid;
   ibdp_beat_type   beat;
   logic            advance;
   ibdp_record_type record;

   assign advance = beat_valid && (!beat.last_byte || !rsp_ch.valid || rsp_ch.ready);

   ibdp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   ibdp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .beat   (beat),
      .record (record)
   );

   ibdp_rsp_stage u_rsp_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (advance && beat.last_byte),
      .record (record),
      .rsp_ch (rsp_ch)
   );

   // A record only ever follows a last byte that has gone through the sequencer.
   a_record_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(advance && beat.last_byte))
      else $error("record raised without a completed last byte");

   // Resistance can only have been decoded when its flag bit was received.
   a_resistance_flagged: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.has_resistance |-> rsp_ch.flag_word[SLOT_RESIST])
      else $error("resistance reported without its flag bit");

   // Input back-pressure arises only from a last byte blocked behind an unread record.
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> beat_valid && beat.last_byte && rsp_ch.valid && !rsp_ch.ready)
      else $error("input stalled without a blocked record");

endmodule

### dv/ibdp_tb_pkg.sv
// Field layout helpers shared by the packet generator and the record checker.
`timescale 1ns / 1ps

package ibdp_tb_pkg;
   import ibdp_pkg::*;

   // Whether the field in this slot is carried under the given flag word.
   function automatic bit slot_present(input logic [15:0] flags, input logic [3:0] slot);
      if (slot == SLOT_SPEED) begin
         return !flags[0];
      end
      return (slot < SLOT_DONE) && flags[slot];
   endfunction

   function automatic int unsigned slot_bytes(input logic [3:0] slot);
      case (slot)
         SLOT_DISTANCE:              return 3;
         SLOT_ENERGY:                return 5;
         SLOT_HEART, SLOT_METABOLIC: return 1;
         SLOT_DONE:                  return 0;
         default:                    return 2;
      endcase
   endfunction

   function automatic logic [3:0] next_slot(input logic [15:0] flags, input logic [3:0] from);
      logic [3:0] slot;
      slot = from;
      while (slot < SLOT_DONE && !slot_present(flags, slot)) begin
         slot = slot + 4'd1;
      end
      return slot;
   endfunction

endpackage

### dv/ibdp_checker.sv
// Record checker: decodes accepted packet bytes and compares every record sent by the parser.
`timescale 1ns / 1ps

module ibdp_checker
   import ibdp_pkg::*;
   import ibdp_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ibdp_req_if         req_mon,
   ibdp_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending
);

   logic [15:0]     flags;
   logic [1:0]      header_seen;
   logic [3:0]      slot;
   logic [2:0]      slot_count;
   logic [23:0]     gather;
   ibdp_record_type decoded;
   ibdp_record_type want;
   ibdp_record_type expected_records[$];

   task automatic report(input string what, input logic [23:0] got, input logic [23:0] exp_val);
      $display("ibdp_checker: %s: got %0h, expected %0h at %0t", what, got, exp_val, $realtime);
      fail_count++;
   endtask

   task automatic clear_packet();
      flags       = '0;
      header_seen = '0;
      slot        = SLOT_SPEED;
      slot_count  = '0;
      gather      = '0;
      decoded     = '0;
   endtask

   task automatic decode_byte(input logic [7:0] data, input logic last);
      ibdp_record_type rec;
      if (header_seen < HEADER_BYTES) begin
         if (header_seen == 2'd0) begin
            flags = {8'h00, data};
         end else begin
            flags[15:8] = data;
         end
         header_seen = header_seen + 2'd1;
         if (header_seen == HEADER_BYTES) begin
            slot       = next_slot(flags, SLOT_SPEED);
            slot_count = '0;
            gather     = '0;
         end
      end else if (slot != SLOT_DONE) begin
         // Only the first three bytes of a field are ever kept.
         if (slot_count < 3'd3) begin
            gather[8*slot_count +: 8] = data;
         end
         slot_count = slot_count + 3'd1;
         if (slot_count == slot_bytes(slot)) begin
            case (slot)
               SLOT_SPEED:    decoded.speed_raw    = gather[15:0];
               SLOT_CADENCE:  decoded.cadence_raw  = gather[15:0];
               SLOT_DISTANCE: decoded.distance_m   = gather;
               SLOT_RESIST: begin
                  decoded.resistance_level = gather[15:0];
                  decoded.has_resistance   = 1'b1;
               end
               SLOT_POWER:    decoded.power_w      = gather[15:0];
               SLOT_ENERGY:   decoded.energy_total = gather[15:0];
               SLOT_HEART:    decoded.heart_rate   = gather[7:0];
               SLOT_ELAPSED:  decoded.elapsed_s    = gather[15:0];
               default: ;
            endcase
            slot       = next_slot(flags, slot + 4'd1);
            slot_count = '0;
            gather     = '0;
         end
      end
      if (last) begin
         rec              = decoded;
         rec.record_valid = (header_seen == HEADER_BYTES) && (slot == SLOT_DONE);
         rec.flag_word    = (header_seen == HEADER_BYTES) ? flags : 16'h0000;
         expected_records.push_back(rec);
         clear_packet();
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      clear_packet();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_packet();
      end else begin
         // Compare before decoding, so a record can never match the beat taken at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_records.size() == 0) begin
               report("record with none pending, flag_word", {8'h00, rsp_mon.flag_word},
                      24'h0);
            end else begin
               want = expected_records.pop_front();
               if (rsp_mon.record_valid !== want.record_valid)
                  report("record_valid", {23'h0, rsp_mon.record_valid},
                         {23'h0, want.record_valid});
               if (rsp_mon.flag_word !== want.flag_word)
                  report("flag_word", {8'h00, rsp_mon.flag_word}, {8'h00, want.flag_word});
               if (rsp_mon.speed_raw !== want.speed_raw)
                  report("speed_raw", {8'h00, rsp_mon.speed_raw}, {8'h00, want.speed_raw});
               if (rsp_mon.cadence_raw !== want.cadence_raw)
                  report("cadence_raw", {8'h00, rsp_mon.cadence_raw},
                         {8'h00, want.cadence_raw});
               if (rsp_mon.distance_m !== want.distance_m)
                  report("distance_m", rsp_mon.distance_m, want.distance_m);
               if (rsp_mon.resistance_level !== want.resistance_level)
                  report("resistance_level", {8'h00, rsp_mon.resistance_level},
                         {8'h00, want.resistance_level});
               if (rsp_mon.has_resistance !== want.has_resistance)
                  report("has_resistance", {23'h0, rsp_mon.has_resistance},
                         {23'h0, want.has_resistance});
               if (rsp_mon.power_w !== want.power_w)
                  report("power_w", {8'h00, rsp_mon.power_w}, {8'h00, want.power_w});
               if (rsp_mon.energy_total !== want.energy_total)
                  report("energy_total", {8'h00, rsp_mon.energy_total},
                         {8'h00, want.energy_total});
               if (rsp_mon.heart_rate !== want.heart_rate)
                  report("heart_rate", {16'h0000, rsp_mon.heart_rate},
                         {16'h0000, want.heart_rate});
               if (rsp_mon.elapsed_s !== want.elapsed_s)
                  report("elapsed_s", {8'h00, rsp_mon.elapsed_s}, {8'h00, want.elapsed_s});
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            decode_byte(req_mon.data_byte, req_mon.last_byte);
         end
      end
      pending = expected_records.size();
   end

endmodule

### dv/tb.sv
// Testbench top: clock, reset, packet stimulus, record back-pressure and the final verdict.
`timescale 1ns / 1ps

module tb
   import ibdp_pkg::*;
   import ibdp_tb_pkg::*;
();

   localparam int SHAPE_WHOLE     = 0;
   localparam int SHAPE_TRAILING  = 1;
   localparam int SHAPE_TRUNCATED = 2;
   localparam int FILL_RANDOM     = -1;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned bytes_sent;
   int unsigned packets_sent;
   logic [7:0]  pkt_bytes[$];

   ibdp_req_if req_if();
   ibdp_rsp_if rsp_if();

   indoor_bike_data_parser_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   ibdp_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // Presents one beat at a falling edge and holds it until the parser takes it.
   task automatic send_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.last_byte <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt_bytes.size(); i++) begin
         send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
      end
      packets_sent++;
   endtask

   task automatic make_packet(input logic [15:0] flags, input int fill, input int shape);
      int unsigned keep;
      pkt_bytes.delete();
      pkt_bytes.push_back(flags[7:0]);
      pkt_bytes.push_back(flags[15:8]);
      for (int s = 0; s < FIELD_COUNT; s++) begin
         if (slot_present(flags, 4'(s))) begin
            repeat (slot_bytes(4'(s))) begin
               pkt_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
            end
         end
      end
      if (shape == SHAPE_TRAILING) begin
         repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom_range(255)));
      end else if (shape == SHAPE_TRUNCATED) begin
         keep = $urandom_range(1, pkt_bytes.size() - 1);
         while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
      end
   endtask

   task automatic random_packets(input int unsigned byte_goal, input int unsigned packet_goal);
      int unsigned    start_bytes;
      int unsigned    start_packets;
      int unsigned    roll;
      logic [15:0]    flags;
      start_bytes   = bytes_sent;
      start_packets = packets_sent;
      while (bytes_sent - start_bytes < byte_goal ||
             packets_sent - start_packets < packet_goal) begin
         flags = 16'($urandom_range(65535));
         // Half the packets carry a thinner flag word, which keeps them short.
         if ($urandom_range(1)) flags = flags & 16'($urandom_range(65535));
         roll = $urandom_range(99);
         if (roll < 70) begin
            make_packet(flags, FILL_RANDOM, SHAPE_WHOLE);
         end else if (roll < 85) begin
            make_packet(flags, FILL_RANDOM, SHAPE_TRAILING);
         end else begin
            make_packet(flags, FILL_RANDOM, SHAPE_TRUNCATED);
         end
         send_packet();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      rsp_if.ready     = 1'b0;
      send_idle_pct    = 9;
      recv_idle_pct    = 48;
      bytes_sent       = 0;
      packets_sent     = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A packet cut inside the flag word.
      pkt_bytes = '{8'hA5};
      send_packet();
      make_packet(16'h0001, 0, SHAPE_WHOLE);
      send_packet();
      // Flag bits above the last field, followed by bytes past the end.
      make_packet(16'hF001, FILL_RANDOM, SHAPE_TRAILING);
      send_packet();
      make_packet(16'h0FFE, 8'hFF, SHAPE_WHOLE);
      send_packet();
      make_packet(16'h0FFF, 8'h00, SHAPE_WHOLE);
      send_packet();
      // Most negative resistance beside the largest power.
      pkt_bytes = '{8'h61, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F};
      send_packet();
      // Distance cut short: the partial field must read as zero.
      pkt_bytes = '{8'h11, 8'h00, 8'h34, 8'h12};
      send_packet();
      // Speed complete, cadence cut after one byte.
      pkt_bytes = '{8'h04, 8'h00, 8'h34, 8'h12, 8'h56};
      send_packet();
      make_packet(16'hFFFF, FILL_RANDOM, SHAPE_TRUNCATED);
      send_packet();

      random_packets(120, 10);
      send_idle_pct = 48;
      recv_idle_pct = 9;
      random_packets(120, 10);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_packets(120, 10);

      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
